>>> src/lpht_pkg.sv
package lpht_pkg;

    // field widths of one request and one result
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    // default number of slots
    localparam int TABLE_SIZE_DEF = 16;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   value_out;
        logic [SLOT_W-1:0]  slot;
    } t_rsp;

    // one slot of the table as held in memory
    typedef struct packed {
        logic               vld;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_RESP
    } t_state;

endpackage

>>> src/lpht_mod.sv
module lpht_mod
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [KEY_W-1:0]              i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem
);

    localparam int  W      = $clog2(TABLE_SIZE);
    localparam bit  IsPow2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

    logic         r_done;
    logic [W-1:0] r_rem;

    assign o_done = r_done;
    assign o_rem  = r_rem;

    generate
        if (IsPow2) begin : g_mask
            // power of two: remainder is the low bits
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_key[W-1:0];
                end
            end
        end else begin : g_recip
            // other sizes: quotient by reciprocal multiply, then key minus quotient times size
            localparam int               QuoW   = KEY_W + 1 - W;
            localparam int               ShiftW = KEY_W + W;
            localparam logic [KEY_W:0]   Recip  =
                (KEY_W+1)'(((longint'(1) << ShiftW) / longint'(TABLE_SIZE)) + 1);
            localparam logic [KEY_W-1:0] SizeK  = KEY_W'(TABLE_SIZE);

            logic              r_phase1;
            logic              r_phase2;
            logic [KEY_W-1:0]  r_key;
            logic [QuoW-1:0]   r_quo;
            logic [2*KEY_W:0]  prod;
            logic [KEY_W-1:0]  back;
            logic [KEY_W-1:0]  diff;

            always_comb begin
                prod = (2*KEY_W+1)'(r_key) * (2*KEY_W+1)'(Recip);
                back = KEY_W'(r_quo) * SizeK;
                diff = r_key - back;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_phase1 <= 1'b0;
                    r_phase2 <= 1'b0;
                    r_done   <= 1'b0;
                end else begin
                    r_phase1 <= i_start;
                    r_phase2 <= r_phase1;
                    r_done   <= r_phase2;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                end
                if (r_phase1) begin
                    r_quo <= prod[ShiftW +: QuoW];
                end
                if (r_phase2) begin
                    r_rem <= diff[W-1:0];
                end
            end
        end
    endgenerate

endmodule

>>> src/lpht_store.sv
module lpht_store
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_waddr,
    input  t_entry                        i_wdata,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_raddr,
    output t_entry                        o_rdata
);

    t_entry r_mem [TABLE_SIZE];
    t_entry r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/linear_probe_hash_table_core.sv
// open-addressing hash table with linear probing over TABLE_SIZE slots. each request
// either inserts/updates a key with a value or looks a key up, and gives exactly one
// result. the home slot is key mod TABLE_SIZE; probing walks forward with wraparound
// for at most TABLE_SIZE slots. after reset the block first runs a clearing pass over
// every slot of the slot memory and accepts no request until it is done.
// requests are handled one at a time: accept in S_IDLE, then the home slot
// computation (registered low key bits when TABLE_SIZE is a power of two, else
// through the remainder unit, a reciprocal multiply followed by a multiply-back),
// then a read and a check per probed slot, set by the single registered read port of
// the slot memory, then S_RESP to load the result register once it is free.
// the result register lets a new request start while the last result waits.
module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int          W        = $clog2(TABLE_SIZE);
    localparam logic [W-1:0] LastSlot = W'(TABLE_SIZE - 1);

    // sequencer state
    t_state r_state;
    t_state n_state;

    // captured request and probe position
    t_action          r_action;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [W-1:0]     r_pos;
    logic [W-1:0]     r_probe;
    logic [W-1:0]     r_clr_addr;

    // pending result and output register
    t_rsp r_res;
    t_rsp r_out;
    logic r_out_valid;

    // remainder unit
    logic         mod_start;
    logic         mod_done;
    logic [W-1:0] mod_rem;

    // slot memory
    logic         mem_we;
    logic [W-1:0] mem_waddr;
    t_entry       mem_wdata;
    t_entry       mem_rdata;

    // probe decode
    logic              slot_empty;
    logic              slot_hit;
    logic              probe_last;
    logic              out_free;
    logic [W+SLOT_W-1:0] slot_ext;
    logic [SLOT_W-1:0] pos_slot;
    logic              accept;

    lpht_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_in_data.key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lpht_store #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_pos),
        .o_rdata (mem_rdata)
    );

    // slot read in S_READ arrives registered in S_CHECK
    assign slot_empty = !mem_rdata.vld;
    assign slot_hit   = mem_rdata.vld && (mem_rdata.key == r_key);
    assign probe_last = (r_probe == LastSlot);
    assign out_free   = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // slot field carries the low bits of the index
    assign slot_ext = {{SLOT_W{1'b0}}, r_pos};
    assign pos_slot = slot_ext[SLOT_W-1:0];

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LastSlot) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (slot_empty || slot_hit || probe_last) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        mod_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = '{vld: 1'b1, key: r_key, value: r_value};
        unique case (r_state)
            S_CLEAR: begin
                // sweep one slot per cycle to clear the valid bits
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                mod_start  = i_in_valid;
            end
            S_CHECK: begin
                // on insert, fill an empty slot, or overwrite the value of a matching key
                mem_we = (r_action == ACT_INSERT) && (slot_empty || slot_hit);
            end
            S_HASH, S_READ, S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_in_data.action;
            r_key    <= i_in_data.key;
            r_value  <= i_in_data.value;
        end

        if (r_state == S_HASH && mod_done) begin
            r_pos   <= mod_rem;
            r_probe <= '0;
        end else if (r_state == S_CHECK && !(slot_empty || slot_hit || probe_last)) begin
            // step to the next slot with wraparound
            r_pos   <= (r_pos == LastSlot) ? '0 : r_pos + 1'b1;
            r_probe <= r_probe + 1'b1;
        end

        if (r_state == S_CHECK) begin
            if (slot_empty) begin
                if (r_action == ACT_LOOKUP) begin
                    r_res <= '{status: ST_NOT_FOUND, value_out: '0, slot: '0};
                end else begin
                    r_res <= '{status: ST_INSERTED, value_out: '0, slot: pos_slot};
                end
            end else if (slot_hit) begin
                if (r_action == ACT_LOOKUP) begin
                    r_res <= '{status: ST_FOUND, value_out: mem_rdata.value, slot: pos_slot};
                end else begin
                    r_res <= '{status: ST_UPDATED, value_out: '0, slot: pos_slot};
                end
            end else if (r_action == ACT_LOOKUP) begin
                // every slot probed without a match
                r_res <= '{status: ST_NOT_FOUND, value_out: '0, slot: '0};
            end else begin
                r_res <= '{status: ST_FULL, value_out: '0, slot: '0};
            end
        end

        if (r_state == S_RESP && out_free) begin
            r_out <= r_res;
        end
    end

endmodule
